// ===== src/assert_macros.svh =====
// Assertion macros shared by the packet statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/pts_pkg.sv =====
// Package with widths, constants and the bucket function of the packet statistics block.
`default_nettype none
package pts_pkg;
   localparam int COUNT_WIDTH_DEFAULT = 48;
   localparam int OUT_W     = 48;
   localparam int LEN_W     = 16;
   localparam int TS_W      = 48;
   localparam int CFG_W     = 27;
   localparam int BUCKETS   = 7;
   localparam int BUCKET_W  = 3;
   localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(1000);

   localparam logic [LEN_W-1:0] BOUND_64   = LEN_W'(64);
   localparam logic [LEN_W-1:0] BOUND_128  = LEN_W'(128);
   localparam logic [LEN_W-1:0] BOUND_256  = LEN_W'(256);
   localparam logic [LEN_W-1:0] BOUND_512  = LEN_W'(512);
   localparam logic [LEN_W-1:0] BOUND_1024 = LEN_W'(1024);
   localparam logic [LEN_W-1:0] BOUND_1518 = LEN_W'(1518);

   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [LEN_W-1:0] len);
      logic [BUCKET_W-1:0] b;
      if (len < BOUND_64) begin
         b = BUCKET_W'(0);
      end else if (len < BOUND_128) begin
         b = BUCKET_W'(1);
      end else if (len < BOUND_256) begin
         b = BUCKET_W'(2);
      end else if (len < BOUND_512) begin
         b = BUCKET_W'(3);
      end else if (len < BOUND_1024) begin
         b = BUCKET_W'(4);
      end else if (len < BOUND_1518) begin
         b = BUCKET_W'(5);
      end else begin
         b = BUCKET_W'(6);
      end
      return b;
   endfunction
endpackage
`default_nettype wire

// ===== src/pts_req_if.sv =====
// Channel interface for packet records entering the statistics block.
`default_nettype none
interface pts_req_if import pts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] pkt_length;
   logic [TS_W-1:0]  timestamp_ms;
   logic             has_error;

   modport source (output valid, output pkt_length, output timestamp_ms, output has_error,
                   input ready);
   modport sink   (input valid, input pkt_length, input timestamp_ms, input has_error,
                   output ready);
endinterface
`default_nettype wire

// ===== src/pts_rsp_if.sv =====
// Channel interface for the statistics results leaving the block.
`default_nettype none
interface pts_rsp_if import pts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_W-1:0]    total_packets;
   logic [OUT_W-1:0]    total_bytes;
   logic [LEN_W-1:0]    min_size;
   logic [LEN_W-1:0]    max_size;
   logic [BUCKET_W-1:0] bucket_index;
   logic [OUT_W-1:0]    bucket_count;
   logic [OUT_W-1:0]    error_count;
   logic                interval_closed;
   logic [OUT_W-1:0]    closed_packets;
   logic [OUT_W-1:0]    closed_bytes;
   logic [OUT_W-1:0]    peak_packets;
   logic [OUT_W-1:0]    peak_bytes;

   modport source (output valid, output total_packets, output total_bytes, output min_size,
                   output max_size, output bucket_index, output bucket_count,
                   output error_count, output interval_closed, output closed_packets,
                   output closed_bytes, output peak_packets, output peak_bytes,
                   input ready);
   modport sink   (input valid, input total_packets, input total_bytes, input min_size,
                   input max_size, input bucket_index, input bucket_count,
                   input error_count, input interval_closed, input closed_packets,
                   input closed_bytes, input peak_packets, input peak_bytes,
                   output ready);
endinterface
`default_nettype wire

// ===== src/pts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pts_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 7
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== src/packet_traffic_statistics.sv =====
// Top level of the packet traffic statistics block: counters, interval rate and size histogram.
//
// Packet records arrive on req_chan (valid/ready); every accepted record gives exactly one
// result on rsp_chan. A transfer on req_chan happens when valid and ready are both high.
// The block takes one record per cycle while req_chan.ready is high. Each result passes a
// pipeline stage: the histogram read from the bucket memory completes in the following cycle,
// the increment is written back then and the result enters a three-entry output queue.
// The rate is set by that read-modify-write of the histogram memory, which forwards the
// last written count so that back-to-back packets of one bucket stay correct.
// Totals, length extremes, error count and interval bookkeeping are registers updated in
// the cycle of the transfer. csr_wr_en writes the interval length (in milliseconds).
// Reset clears every counter and restores the interval length to 1000 ms; the histogram
// is cleared at once by its per-bucket valid bits, so no clearing pass is needed.
// req_chan.ready is held low while reset is asserted.
// When the receiver stalls, up to three results wait in the queue and req_chan.ready
// falls once the queue and the pipeline stage would otherwise overflow; nothing is lost.
`default_nettype none
`include "assert_macros.svh"
module packet_traffic_statistics import pts_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   pts_req_if.sink               req_chan,
   pts_rsp_if.source             rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);
   localparam int FIFO_DEPTH = 3;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam logic [BUCKET_W-1:0] TOP_BUCKET = BUCKET_W'(BUCKETS - 1);

   typedef struct packed {
      logic [OUT_W-1:0]    total_packets;
      logic [OUT_W-1:0]    total_bytes;
      logic [LEN_W-1:0]    min_size;
      logic [LEN_W-1:0]    max_size;
      logic [BUCKET_W-1:0] bucket_index;
      logic [OUT_W-1:0]    bucket_count;
      logic [OUT_W-1:0]    error_count;
      logic                interval_closed;
      logic [OUT_W-1:0]    closed_packets;
      logic [OUT_W-1:0]    closed_bytes;
      logic [OUT_W-1:0]    peak_packets;
      logic [OUT_W-1:0]    peak_bytes;
   } result_type;

   logic [CFG_W-1:0]       interval_ms_ff;
   logic                   started_ff;
   logic [COUNT_WIDTH-1:0] pkt_total_ff, pkt_total_in;
   logic [COUNT_WIDTH-1:0] byte_total_ff, byte_total_in;
   logic [LEN_W-1:0]       smallest_ff, smallest_in;
   logic [LEN_W-1:0]       largest_ff, largest_in;
   logic [COUNT_WIDTH-1:0] errors_ff, errors_in;
   logic [TS_W-1:0]        istart_ff, istart_in;
   logic [COUNT_WIDTH-1:0] ipkts_ff, ipkts_in;
   logic [COUNT_WIDTH-1:0] ibytes_ff, ibytes_in;
   logic [COUNT_WIDTH-1:0] peak_pk_ff, peak_pk_in;
   logic [COUNT_WIDTH-1:0] peak_by_ff, peak_by_in;

   logic [BUCKETS-1:0]     hist_valid_ff;
   logic                   fwd_valid_ff;
   logic [BUCKET_W-1:0]    fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   logic                   s1_valid_ff;
   result_type             s1_ff, s1_in;

   result_type             fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       fifo_cnt_ff;

   logic                   accept, pop;
   logic [CNT_W:0]         occupancy;
   logic [LEN_W-1:0]       len;
   logic [TS_W-1:0]        ts;
   logic [TS_W-1:0]        start_eff, diff;
   logic                   closed;
   logic [COUNT_WIDTH-1:0] len_c;
   logic [BUCKET_W-1:0]    bucket;
   logic [COUNT_WIDTH-1:0] ram_q, hist_old, hist_new;
   result_type             push_entry;

   // Pipeline stage and queue together may hold at most the queue depth.
   assign occupancy      = {1'b0, fifo_cnt_ff} + (CNT_W + 1)'(s1_valid_ff);
   assign req_chan.ready = !reset && (occupancy < (CNT_W + 1)'(FIFO_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   assign len    = req_chan.pkt_length;
   assign ts     = req_chan.timestamp_ms;
   assign len_c  = COUNT_WIDTH'(len);
   assign bucket = bucket_of(len);

   always_comb begin
      start_eff = started_ff ? istart_ff : ts;
      diff      = ts - start_eff;
      // The difference is read as signed: a timestamp behind the start never closes.
      closed    = !diff[TS_W-1] && (diff >= TS_W'(interval_ms_ff));

      pkt_total_in  = pkt_total_ff + COUNT_WIDTH'(1);
      byte_total_in = byte_total_ff + len_c;
      smallest_in   = ((smallest_ff == '0) || (len < smallest_ff)) ? len : smallest_ff;
      largest_in    = (len > largest_ff) ? len : largest_ff;
      errors_in     = req_chan.has_error ? errors_ff + COUNT_WIDTH'(1) : errors_ff;
      peak_pk_in    = (closed && (ipkts_ff > peak_pk_ff)) ? ipkts_ff : peak_pk_ff;
      peak_by_in    = (closed && (ibytes_ff > peak_by_ff)) ? ibytes_ff : peak_by_ff;
      istart_in     = closed ? start_eff + TS_W'(interval_ms_ff) : start_eff;
      ipkts_in      = (closed ? '0 : ipkts_ff) + COUNT_WIDTH'(1);
      ibytes_in     = (closed ? '0 : ibytes_ff) + len_c;

      s1_in.total_packets   = OUT_W'(pkt_total_in);
      s1_in.total_bytes     = OUT_W'(byte_total_in);
      s1_in.min_size        = smallest_in;
      s1_in.max_size        = largest_in;
      s1_in.bucket_index    = bucket;
      s1_in.bucket_count    = '0;
      s1_in.error_count     = OUT_W'(errors_in);
      s1_in.interval_closed = closed;
      s1_in.closed_packets  = closed ? OUT_W'(ipkts_ff) : '0;
      s1_in.closed_bytes    = closed ? OUT_W'(ibytes_ff) : '0;
      s1_in.peak_packets    = OUT_W'(peak_pk_in);
      s1_in.peak_bytes      = OUT_W'(peak_by_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ms_ff <= INTERVAL_RESET;
         started_ff     <= 1'b0;
         pkt_total_ff   <= '0;
         byte_total_ff  <= '0;
         smallest_ff    <= '0;
         largest_ff     <= '0;
         errors_ff      <= '0;
         istart_ff      <= '0;
         ipkts_ff       <= '0;
         ibytes_ff      <= '0;
         peak_pk_ff     <= '0;
         peak_by_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            interval_ms_ff <= csr_wr_data;
         end
         if (accept) begin
            started_ff    <= 1'b1;
            pkt_total_ff  <= pkt_total_in;
            byte_total_ff <= byte_total_in;
            smallest_ff   <= smallest_in;
            largest_ff    <= largest_in;
            errors_ff     <= errors_in;
            istart_ff     <= istart_in;
            ipkts_ff      <= ipkts_in;
            ibytes_ff     <= ibytes_in;
            peak_pk_ff    <= peak_pk_in;
            peak_by_ff    <= peak_by_in;
         end
      end
   end

   // Histogram memory: read at the transfer, incremented and written back in the following cycle.
   pts_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BUCKETS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.bucket_index),
      .wr_data (hist_new),
      .rd_en   (accept),
      .rd_addr (bucket),
      .rd_data (ram_q)
   );

   always_comb begin
      // The previous write landed in the same cycle as this read, so it is forwarded.
      if (fwd_valid_ff && (fwd_addr_ff == s1_ff.bucket_index)) begin
         hist_old = fwd_data_ff;
      end else if (hist_valid_ff[s1_ff.bucket_index]) begin
         hist_old = ram_q;
      end else begin
         hist_old = '0;
      end
      hist_new = hist_old + COUNT_WIDTH'(1);

      push_entry              = s1_ff;
      push_entry.bucket_count = OUT_W'(hist_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         fwd_valid_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            hist_valid_ff[s1_ff.bucket_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff) begin
         fwd_addr_ff <= s1_ff.bucket_index;
         fwd_data_ff <= hist_new;
      end
   end

   // Output queue.
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(s1_valid_ff) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign rsp_chan.valid           = fifo_cnt_ff != '0;
   assign rsp_chan.total_packets   = fifo_ff[rd_ptr_ff].total_packets;
   assign rsp_chan.total_bytes     = fifo_ff[rd_ptr_ff].total_bytes;
   assign rsp_chan.min_size        = fifo_ff[rd_ptr_ff].min_size;
   assign rsp_chan.max_size        = fifo_ff[rd_ptr_ff].max_size;
   assign rsp_chan.bucket_index    = fifo_ff[rd_ptr_ff].bucket_index;
   assign rsp_chan.bucket_count    = fifo_ff[rd_ptr_ff].bucket_count;
   assign rsp_chan.error_count     = fifo_ff[rd_ptr_ff].error_count;
   assign rsp_chan.interval_closed = fifo_ff[rd_ptr_ff].interval_closed;
   assign rsp_chan.closed_packets  = fifo_ff[rd_ptr_ff].closed_packets;
   assign rsp_chan.closed_bytes    = fifo_ff[rd_ptr_ff].closed_bytes;
   assign rsp_chan.peak_packets    = fifo_ff[rd_ptr_ff].peak_packets;
   assign rsp_chan.peak_bytes      = fifo_ff[rd_ptr_ff].peak_bytes;

   `ASSERT_ALWAYS(a_fifo_bound, clock, reset, fifo_cnt_ff <= CNT_W'(FIFO_DEPTH), "count too high")
   `ASSERT_ALWAYS(a_no_overflow, clock, reset, occupancy <= (CNT_W + 1)'(FIFO_DEPTH), "overrun")
   `ASSERT_NEXT(a_stage_fill, clock, reset, accept, s1_valid_ff, "stage not filled")
   `ASSERT_IMPLIES(a_bucket_range, clock, reset, accept, bucket <= TOP_BUCKET, "bad bucket")
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the packet traffic statistics block.
module tb_top;
   import pts_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int STALL_AFTER   = 350;
   localparam int STALL_CYCLES  = 80;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 135;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [TS_W-1:0] NEAR_WRAP = 48'hFFFF_FFFF_FC00;
   localparam logic [TS_W-1:0] HALF_SPAN = 48'h8000_0000_0000;

   typedef struct {
      logic [OUT_W-1:0]    total_packets;
      logic [OUT_W-1:0]    total_bytes;
      logic [LEN_W-1:0]    min_size;
      logic [LEN_W-1:0]    max_size;
      logic [BUCKET_W-1:0] bucket_index;
      logic [OUT_W-1:0]    bucket_count;
      logic [OUT_W-1:0]    error_count;
      logic                interval_closed;
      logic [OUT_W-1:0]    closed_packets;
      logic [OUT_W-1:0]    closed_bytes;
      logic [OUT_W-1:0]    peak_packets;
      logic [OUT_W-1:0]    peak_bytes;
   } traffic_stats_type;

   // Tracks the statistics the block should report and checks each result against them.
   class traffic_stats_scoreboard;
      logic [CFG_W-1:0]  interval_len;
      bit                started;
      logic [OUT_W-1:0]  pkt_total;
      logic [OUT_W-1:0]  byte_total;
      logic [LEN_W-1:0]  min_len;
      logic [LEN_W-1:0]  max_len;
      logic [OUT_W-1:0]  hist [BUCKETS];
      logic [OUT_W-1:0]  err_total;
      logic [TS_W-1:0]   win_start;
      logic [OUT_W-1:0]  win_pkts;
      logic [OUT_W-1:0]  win_bytes;
      logic [OUT_W-1:0]  peak_pkts;
      logic [OUT_W-1:0]  peak_bytes;
      traffic_stats_type pending_stats [$];
      int                mismatches;

      function new();
         interval_len = INTERVAL_RESET;
         started      = 1'b0;
         pkt_total    = '0;
         byte_total   = '0;
         min_len      = '0;
         max_len      = '0;
         foreach (hist[i]) hist[i] = '0;
         err_total    = '0;
         win_start    = '0;
         win_pkts     = '0;
         win_bytes    = '0;
         peak_pkts    = '0;
         peak_bytes   = '0;
         mismatches   = 0;
      endfunction

      function void set_interval(input logic [CFG_W-1:0] value);
         interval_len = value;
      endfunction

      function logic [BUCKET_W-1:0] size_class(input logic [LEN_W-1:0] len);
         if (len >= BOUND_1518) return BUCKET_W'(6);
         if (len >= BOUND_1024) return BUCKET_W'(5);
         if (len >= BOUND_512)  return BUCKET_W'(4);
         if (len >= BOUND_256)  return BUCKET_W'(3);
         if (len >= BOUND_128)  return BUCKET_W'(2);
         if (len >= BOUND_64)   return BUCKET_W'(1);
         return BUCKET_W'(0);
      endfunction

      function void note_packet(input logic [LEN_W-1:0] len, input logic [TS_W-1:0] ts,
                                input logic err);
         traffic_stats_type   want;
         logic [TS_W-1:0]     elapsed;
         logic [BUCKET_W-1:0] b;
         pkt_total  = pkt_total + 1'b1;
         byte_total = byte_total + OUT_W'(len);
         if (!started) begin
            started   = 1'b1;
            win_start = ts;
         end
         if (min_len == '0 || len < min_len) min_len = len;
         if (len > max_len) max_len = len;
         want.interval_closed = 1'b0;
         want.closed_packets  = '0;
         want.closed_bytes    = '0;
         // The elapsed time is read as a signed value; a packet from the past never closes.
         elapsed = ts - win_start;
         if (!elapsed[TS_W-1] && elapsed >= TS_W'(interval_len)) begin
            want.interval_closed = 1'b1;
            want.closed_packets  = win_pkts;
            want.closed_bytes    = win_bytes;
            if (win_pkts > peak_pkts) peak_pkts = win_pkts;
            if (win_bytes > peak_bytes) peak_bytes = win_bytes;
            win_start = win_start + TS_W'(interval_len);
            win_pkts  = '0;
            win_bytes = '0;
         end
         win_pkts  = win_pkts + 1'b1;
         win_bytes = win_bytes + OUT_W'(len);
         b = size_class(len);
         hist[b] = hist[b] + 1'b1;
         if (err) err_total = err_total + 1'b1;
         want.total_packets = pkt_total;
         want.total_bytes   = byte_total;
         want.min_size      = min_len;
         want.max_size      = max_len;
         want.bucket_index  = b;
         want.bucket_count  = hist[b];
         want.error_count   = err_total;
         want.peak_packets  = peak_pkts;
         want.peak_bytes    = peak_bytes;
         pending_stats.push_back(want);
      endfunction

      function void compare_field(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(input traffic_stats_type got);
         traffic_stats_type want;
         if (pending_stats.size() == 0) begin
            $error("result transfer arrived with no packet outstanding");
            mismatches++;
            return;
         end
         want = pending_stats.pop_front();
         compare_field("total_packets", want.total_packets, got.total_packets);
         compare_field("total_bytes", want.total_bytes, got.total_bytes);
         compare_field("min_size", want.min_size, got.min_size);
         compare_field("max_size", want.max_size, got.max_size);
         compare_field("bucket_index", want.bucket_index, got.bucket_index);
         compare_field("bucket_count", want.bucket_count, got.bucket_count);
         compare_field("error_count", want.error_count, got.error_count);
         compare_field("interval_closed", want.interval_closed, got.interval_closed);
         compare_field("closed_packets", want.closed_packets, got.closed_packets);
         compare_field("closed_bytes", want.closed_bytes, got.closed_bytes);
         compare_field("peak_packets", want.peak_packets, got.peak_packets);
         compare_field("peak_bytes", want.peak_bytes, got.peak_bytes);
      endfunction

      function int outstanding();
         return pending_stats.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   pts_req_if req_if ();
   pts_rsp_if rsp_if ();

   packet_traffic_statistics u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if.sink),
      .rsp_chan    (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   traffic_stats_scoreboard stats = new();

   logic [TS_W-1:0]  ts_cursor;
   bit               req_burst;
   logic [LEN_W-1:0] boundary_lens [15] = '{16'd0, 16'd1, 16'd63, 16'd64, 16'd127, 16'd128,
                                            16'd255, 16'd256, 16'd511, 16'd512, 16'd1023,
                                            16'd1024, 16'd1517, 16'd1518, 16'd65535};

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offers one packet record and returns once its transfer has taken place.
   task automatic send_packet(input logic [LEN_W-1:0] len, input logic [TS_W-1:0] ts,
                              input logic err);
      int gap;
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        = 1'b1;
      req_if.pkt_length   = len;
      req_if.timestamp_ms = ts;
      req_if.has_error    = err;
      do @(posedge clock); while (!req_if.ready);
      stats.note_packet(len, ts, err);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (stats.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_interval(input logic [CFG_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      stats.set_interval(value);
   endtask

   // Mostly a timestamp stream that moves forward at a pace matched to the interval, with
   // stragglers from the past, wild timestamps and points around the signed boundary mixed in.
   task automatic send_random_packet(input logic [CFG_W-1:0] iv);
      int unsigned      pick;
      int unsigned      span;
      logic [TS_W-1:0]  ts;
      logic [LEN_W-1:0] len;
      span = iv;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         ts_cursor = ts_cursor + TS_W'($urandom_range(0, span / 8 + 1));
         ts = ts_cursor;
      end else if (pick < 75) begin
         ts_cursor = ts_cursor + TS_W'($urandom_range(span / 2, span * 2 + 1));
         ts = ts_cursor;
      end else if (pick < 82) begin
         ts_cursor = stats.win_start + TS_W'(span) - TS_W'($urandom_range(0, 1));
         ts = ts_cursor;
      end else if (pick < 90) begin
         ts = ts_cursor - TS_W'($urandom_range(1, span + 5));
      end else if (pick < 96) begin
         ts = {16'($urandom_range(0, 65535)), 32'($urandom())};
      end else begin
         ts = stats.win_start + (pick[0] ? HALF_SPAN - 1'b1 : HALF_SPAN);
      end
      case ($urandom_range(0, 3))
         0: begin
            len = boundary_lens[$urandom_range(0, 14)];
         end
         1, 2: begin
            len = LEN_W'($urandom_range(0, 1600));
         end
         default: begin
            len = LEN_W'($urandom_range(0, 65535));
         end
      endcase
      send_packet(len, ts, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int unsigned phase_iv [PHASES];
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_if.valid        = 1'b0;
      req_if.pkt_length   = '0;
      req_if.timestamp_ms = '0;
      req_if.has_error    = 1'b0;
      req_burst           = 1'b0;
      ts_cursor           = '0;
      phase_iv = '{1000, 1, 86400000, 0, 27'h2AA_AAAA, 2, 27'h155_5555, 64, 0, 1000};
      phase_iv[5] = $urandom_range(2, 5000);
      phase_iv[8] = $urandom_range(0, 86400000);
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Reset interval length; the first packet sits just below the timestamp wrap so that
      // the interval start wraps through zero.
      send_packet(16'd0, NEAR_WRAP, 1'b0);
      send_packet(16'd100, NEAR_WRAP + 999, 1'b1);
      send_packet(16'd0, NEAR_WRAP + 1000, 1'b0);
      send_packet(16'd50, NEAR_WRAP + 500, 1'b0);
      send_packet(16'd63, 48'h0, 1'b1);
      send_packet(16'd64, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_packet(16'd127, 48'd976, 1'b0);
      send_packet(16'd128, 48'd976 + HALF_SPAN - 1'b1, 1'b0);
      send_packet(16'd255, 48'd1976 + HALF_SPAN, 1'b1);
      for (int i = 7; i < 15; i++) begin
         send_packet(boundary_lens[i], TS_W'(2500 + 300 * i), 1'(i % 2));
      end

      // With a zero interval every packet that is not from the past closes one.
      write_interval('0);
      ts_cursor = stats.win_start;
      send_packet(16'd1, ts_cursor, 1'b0);
      send_packet(16'd2000, ts_cursor - 1'b1, 1'b1);
      send_packet(16'd700, ts_cursor + 5, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         write_interval(CFG_W'(phase_iv[p]));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 60) wait_for_results();
            send_random_packet(CFG_W'(phase_iv[p]));
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (stats.mismatches == 0) begin
         $display("** packet_traffic_statistics: PASSED **");
      end else begin
         $display("** packet_traffic_statistics: FAILED **");
      end
      $finish;
   end

   // Result side: random back-pressure, with one long hold-off that fills the block.
   initial begin
      int                gap;
      int                seen;
      bit                burst;
      traffic_stats_type got;
      rsp_if.ready = 1'b0;
      seen  = 0;
      burst = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 31) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 7);
         if (seen == STALL_AFTER) gap = STALL_CYCLES;
         if (gap != 0) begin
            rsp_if.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.total_packets   = rsp_if.total_packets;
         got.total_bytes     = rsp_if.total_bytes;
         got.min_size        = rsp_if.min_size;
         got.max_size        = rsp_if.max_size;
         got.bucket_index    = rsp_if.bucket_index;
         got.bucket_count    = rsp_if.bucket_count;
         got.error_count     = rsp_if.error_count;
         got.interval_closed = rsp_if.interval_closed;
         got.closed_packets  = rsp_if.closed_packets;
         got.closed_bytes    = rsp_if.closed_bytes;
         got.peak_packets    = rsp_if.peak_packets;
         got.peak_bytes      = rsp_if.peak_bytes;
         stats.check_result(got);
         seen++;
         @(negedge clock);
      end
   end

   // Ends the run if neither channel has seen a transfer for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("** packet_traffic_statistics: FAILED **");
      $finish;
   end
endmodule
